FILE: sv/spq_pkg.sv
// Shared types and codes for the sorted priority queue.
package spq_pkg;

  localparam int unsigned DataW = 32;
  localparam int unsigned PrioW = 16;
  localparam int unsigned StatusW = 3;
  localparam int unsigned OccW = 5;

  typedef enum logic {
    FuncInsert = 1'b0,
    FuncRemove = 1'b1
  } func_e;

  typedef enum logic [StatusW-1:0] {
    StInserted = 3'd0,
    StDropped  = 3'd1,
    StRejected = 3'd2,
    StRemoved  = 3'd3,
    StEmpty    = 3'd4
  } status_e;

  typedef struct packed {
    logic                    valid;
    logic signed [DataW-1:0] data;
    logic        [PrioW-1:0] prio;
  } slot_t;

  typedef struct packed {
    logic                    ins;
    logic                    rem;
    logic signed [DataW-1:0] data;
    logic        [PrioW-1:0] prio;
  } cell_cmd_t;

endpackage

FILE: sv/spq_cell.sv
// One queue slot: holds an entry, compares it to the new priority, shifts with its neighbors.
module spq_cell (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  spq_pkg::cell_cmd_t cmd_i,
  input  spq_pkg::slot_t     prev_slot_i,
  input  logic               prev_le_i,
  input  spq_pkg::slot_t     next_slot_i,
  output spq_pkg::slot_t     slot_o,
  output logic               le_o
);

  logic                            valid_q, valid_d;
  logic signed [spq_pkg::DataW-1:0] data_q, data_d;
  logic        [spq_pkg::PrioW-1:0] prio_q, prio_d;

  assign le_o = valid_q && (prio_q <= cmd_i.prio);
  assign slot_o = '{valid: valid_q, data: data_q, prio: prio_q};

  always_comb begin
    valid_d = valid_q;
    data_d  = data_q;
    prio_d  = prio_q;
    priority if (cmd_i.rem) begin
      valid_d = next_slot_i.valid;
      data_d  = next_slot_i.data;
      prio_d  = next_slot_i.prio;
    end else if (cmd_i.ins && !le_o && prev_le_i) begin
      valid_d = 1'b1;
      data_d  = cmd_i.data;
      prio_d  = cmd_i.prio;
    end else if (cmd_i.ins && !le_o) begin
      valid_d = prev_slot_i.valid;
      data_d  = prev_slot_i.data;
      prio_d  = prev_slot_i.prio;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
    prio_q <= prio_d;
  end

endmodule

FILE: sv/sorted_priority_queue_core.sv
// Top level of the sorted priority queue: a row of slot cells with command and result logic.
// The result of a command accepted at one edge is strobed on done_o the next cycle.
// Throughput: one command per cycle; busy_o stays low since all cells shift together.
// The receiver cannot stall; each result shows for exactly one cycle.
// Reset clears all valid bits and the entry count; the queue comes up empty.
module sorted_priority_queue_core #(
  parameter int unsigned DEPTH = 16
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  output logic                            busy_o,
  input  logic                            func_i,
  input  logic signed [spq_pkg::DataW-1:0] item_data_i,
  input  logic        [spq_pkg::PrioW-1:0] item_priority_i,
  output logic                            done_o,
  output logic      [spq_pkg::StatusW-1:0] status_o,
  output logic signed [spq_pkg::DataW-1:0] out_data_o,
  output logic        [spq_pkg::PrioW-1:0] out_priority_o,
  output logic         [spq_pkg::OccW-1:0] occupancy_o
);

  localparam int unsigned CntBits = $clog2(DEPTH + 1);
  localparam int unsigned CntW = (CntBits > spq_pkg::OccW) ? CntBits : spq_pkg::OccW;

  spq_pkg::slot_t     slots [DEPTH];
  logic [DEPTH-1:0]   le_vec;
  logic [DEPTH-1:0]   valid_vec;
  spq_pkg::cell_cmd_t cmd;

  logic accept, is_ins, is_rem, full, empty, reject;
  logic [CntW-1:0] count_q, count_d;
  logic done_q;
  spq_pkg::status_e status_q, status_d;
  logic signed [spq_pkg::DataW-1:0] odata_q, odata_d;
  logic        [spq_pkg::PrioW-1:0] oprio_q, oprio_d;

  assign busy_o = 1'b0;
  assign accept = start_i && !busy_o;
  assign is_ins = accept && (spq_pkg::func_e'(func_i) == spq_pkg::FuncInsert);
  assign is_rem = accept && (spq_pkg::func_e'(func_i) == spq_pkg::FuncRemove);
  assign full   = valid_vec[DEPTH-1];
  assign empty  = !valid_vec[0];
  assign reject = full && le_vec[DEPTH-1];

  assign cmd = '{ins: is_ins && !reject, rem: is_rem && !empty,
                 data: item_data_i, prio: item_priority_i};

  for (genvar k = 0; k < DEPTH; k++) begin : g_cell
    spq_pkg::slot_t prev_slot, next_slot;
    logic           prev_le;
    if (k == 0) begin : g_first
      assign prev_slot = '0;
      assign prev_le   = 1'b1;
    end else begin : g_mid
      assign prev_slot = slots[k-1];
      assign prev_le   = le_vec[k-1];
    end
    if (k == DEPTH - 1) begin : g_last
      assign next_slot = '0;
    end else begin : g_body
      assign next_slot = slots[k+1];
    end
    assign valid_vec[k] = slots[k].valid;

    spq_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .cmd_i       (cmd),
      .prev_slot_i (prev_slot),
      .prev_le_i   (prev_le),
      .next_slot_i (next_slot),
      .slot_o      (slots[k]),
      .le_o        (le_vec[k])
    );
  end

  always_comb begin
    count_d  = count_q;
    status_d = spq_pkg::StInserted;
    odata_d  = '0;
    oprio_d  = '0;
    if (is_ins) begin
      priority if (reject) begin
        status_d = spq_pkg::StRejected;
      end else if (full) begin
        status_d = spq_pkg::StDropped;
        odata_d  = slots[DEPTH-1].data;
        oprio_d  = slots[DEPTH-1].prio;
      end else begin
        status_d = spq_pkg::StInserted;
        count_d  = count_q + CntW'(1);
      end
    end else if (is_rem) begin
      priority if (empty) begin
        status_d = spq_pkg::StEmpty;
      end else begin
        status_d = spq_pkg::StRemoved;
        odata_d  = slots[0].data;
        oprio_d  = slots[0].prio;
        count_d  = count_q - CntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      done_q  <= 1'b0;
    end else begin
      count_q <= count_d;
      done_q  <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    status_q <= status_d;
    odata_q  <= odata_d;
    oprio_q  <= oprio_d;
  end

  assign done_o         = done_q;
  assign status_o       = status_q;
  assign out_data_o     = odata_q;
  assign out_priority_o = oprio_q;
  assign occupancy_o    = count_q[spq_pkg::OccW-1:0];

  a_count_matches: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q == CntW'($countones(valid_vec)))
    else $error("entry count differs from valid cells");

  a_valid_prefix: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot({1'b0, valid_vec} + {{DEPTH{1'b0}}, 1'b1}))
    else $error("valid cells do not form a prefix");

  a_done_follows_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(accept))
    else $error("result strobe without an accepted command");

  a_reject_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (is_ins && reject) |=> $stable(valid_vec) && (count_q == $past(count_q)))
    else $error("rejected insert changed the queue");

endmodule
